### rtl/lkv_pkg.sv
// Package for the LRU key-value cache: operation codes, the configuration
// register width and reset value, and the action struct used between modules.
// No dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

    // Width and reset value of the capacity register.
    localparam int unsigned CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request codes carried on the operation field.
    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    // What the lookup decided to do with the stored entries.
    typedef struct packed {
        logic touch;   // key present: make the matching entry most recent
        logic write;   // key present and put: overwrite the stored value
        logic fill;    // put miss with room left: take the next free entry
        logic evict;   // put miss at capacity: replace the least recent entry
    } t_lkv_action;

endpackage

### rtl/lkv_lookup.sv
// Combinational lookup of the LRU key-value cache: parallel key compare,
// hit and victim selection, and the result fields. Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_lookup #(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned KEY_BITS    = 16,
    parameter int unsigned VALUE_BITS  = 32,
    parameter int unsigned RANK_W      = 4,
    parameter int unsigned FILL_W      = 5
) (
    input  logic                                    i_op,
    input  logic [KEY_BITS-1:0]                     i_key,
    input  logic [lkv_pkg::CAP_W-1:0]               i_capacity,
    input  logic [MAX_ENTRIES-1:0][KEY_BITS-1:0]    i_keys,
    input  logic [MAX_ENTRIES-1:0][VALUE_BITS-1:0]  i_values,
    input  logic [MAX_ENTRIES-1:0][RANK_W-1:0]      i_ranks,
    input  logic [FILL_W-1:0]                       i_fill,
    output lkv_pkg::t_lkv_action                    o_action,
    output logic [MAX_ENTRIES-1:0]                  o_sel,
    output logic [RANK_W-1:0]                       o_rank_thr,
    output logic                                    o_hit,
    output logic [VALUE_BITS-1:0]                   o_read_value,
    output logic                                    o_evicted,
    output logic [KEY_BITS-1:0]                     o_evicted_key
);
    import lkv_pkg::*;

    localparam int unsigned CMP_W = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] lru;
    logic [MAX_ENTRIES-1:0] slot;
    logic [VALUE_BITS-1:0]  hit_value;
    logic [RANK_W-1:0]      hit_rank;
    logic [KEY_BITS-1:0]    lru_key;
    logic [FILL_W-1:0]      fill_m1;
    logic [RANK_W-1:0]      oldest_rank;
    logic                   below_cap;
    logic                   can_fill;
    logic                   is_put;

    // Valid entries are always the lowest fill-count slots, and their ranks
    // form a permutation of 0 .. fill-1, so the oldest has rank fill-1.
    assign fill_m1     = i_fill - FILL_W'(1);
    assign oldest_rank = fill_m1[RANK_W-1:0];

    always_comb begin
        match     = '0;
        lru       = '0;
        slot      = '0;
        hit_value = '0;
        hit_rank  = '0;
        lru_key   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (FILL_W'(i) < i_fill) begin
                match[i] = (i_keys[i] == i_key);
                lru[i]   = (i_ranks[i] == oldest_rank);
            end
            slot[i]   = (i_fill == FILL_W'(i));
            hit_value = hit_value | (match[i] ? i_values[i] : '0);
            hit_rank  = hit_rank  | (match[i] ? i_ranks[i]  : '0);
            lru_key   = lru_key   | (lru[i]   ? i_keys[i]   : '0);
        end
    end

    // A capacity of zero behaves as one; above the entry count it saturates.
    assign below_cap = (i_capacity == '0) ? (i_fill == '0)
                                          : (CMP_W'(i_fill) < CMP_W'(i_capacity));
    assign can_fill  = (i_fill < FILL_W'(MAX_ENTRIES)) && below_cap;
    assign is_put    = (i_op == OP_PUT);

    assign o_hit          = |match;
    assign o_action.touch = o_hit;
    assign o_action.write = o_hit && is_put;
    assign o_action.fill  = !o_hit && is_put && can_fill;
    assign o_action.evict = !o_hit && is_put && !can_fill;

    always_comb begin
        priority if (o_action.touch) begin
            o_sel      = match;
            o_rank_thr = hit_rank;
        end else if (o_action.fill) begin
            o_sel      = slot;
            o_rank_thr = oldest_rank;
        end else if (o_action.evict) begin
            o_sel      = lru;
            o_rank_thr = oldest_rank;
        end else begin
            o_sel      = '0;
            o_rank_thr = '0;
        end
    end

    assign o_read_value  = (o_hit && !is_put) ? hit_value : '0;
    assign o_evicted     = o_action.evict;
    assign o_evicted_key = o_action.evict ? lru_key : '0;

endmodule

### rtl/lkv_store.sv
// Entry storage of the LRU key-value cache: keys, values, recency ranks and
// the fill count, updated once per processed request. Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_store #(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned KEY_BITS    = 16,
    parameter int unsigned VALUE_BITS  = 32,
    parameter int unsigned RANK_W      = 4,
    parameter int unsigned FILL_W      = 5
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_update,
    input  lkv_pkg::t_lkv_action                    i_action,
    input  logic [MAX_ENTRIES-1:0]                  i_sel,
    input  logic [RANK_W-1:0]                       i_rank_thr,
    input  logic [KEY_BITS-1:0]                     i_key,
    input  logic [VALUE_BITS-1:0]                   i_value,
    output logic [MAX_ENTRIES-1:0][KEY_BITS-1:0]    o_keys,
    output logic [MAX_ENTRIES-1:0][VALUE_BITS-1:0]  o_values,
    output logic [MAX_ENTRIES-1:0][RANK_W-1:0]      o_ranks,
    output logic [FILL_W-1:0]                       o_fill
);
    import lkv_pkg::*;

    logic [MAX_ENTRIES-1:0][KEY_BITS-1:0]   r_keys;
    logic [MAX_ENTRIES-1:0][VALUE_BITS-1:0] r_values;
    logic [MAX_ENTRIES-1:0][RANK_W-1:0]     r_ranks;
    logic [MAX_ENTRIES-1:0][RANK_W-1:0]     n_ranks;
    logic [FILL_W-1:0]                      r_fill;
    logic                                   rank_upd;
    logic                                   new_key;
    logic                                   new_value;

    assign rank_upd  = i_update && (i_action.touch || i_action.fill || i_action.evict);
    assign new_key   = i_update && (i_action.fill || i_action.evict);
    assign new_value = new_key || (i_update && i_action.write);

    // The selected entry becomes rank 0. On a fill every valid entry ages;
    // otherwise only entries younger than the selected one age.
    always_comb begin
        n_ranks = r_ranks;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (rank_upd) begin
                if (i_sel[i]) begin
                    n_ranks[i] = '0;
                end else if ((FILL_W'(i) < r_fill)
                             && (i_action.fill || (r_ranks[i] < i_rank_thr))) begin
                    n_ranks[i] = r_ranks[i] + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ranks <= '0;
            r_fill  <= '0;
        end else begin
            r_ranks <= n_ranks;
            if (i_update && i_action.fill) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (new_key && i_sel[i]) begin
                r_keys[i] <= i_key;
            end
            if (new_value && i_sel[i]) begin
                r_values[i] <= i_value;
            end
        end
    end

    assign o_keys   = r_keys;
    assign o_values = r_values;
    assign o_ranks  = r_ranks;
    assign o_fill   = r_fill;

endmodule

### rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: input register, lookup, entry store
// and result register. Depends on lkv_pkg, lkv_lookup and lkv_store.
`timescale 1ns / 1ps

// A fully associative key-value cache with least-recently-used replacement.
// Each request is a get or a put of a key (and, for a put, a value) and
// yields exactly one result: hit, the stored value on a get hit, and on a put
// miss at capacity the evicted flag with the key of the replaced entry. A
// request is held first in the input register and then in the result
// register; one request is accepted every cycle while the result side keeps
// up. The key compare across all entries, the choice of the victim and the
// recency update all sit between those two registers, and the entry state is
// written at the same edge that loads the result, so back-to-back requests
// always see each other's effects. Recency is a rank per entry, 0 being the
// most recent. The capacity register (reset 16) limits how many entries fill
// before eviction starts; zero acts as one and values above MAX_ENTRIES act
// as MAX_ENTRIES. Lowering it below the current fill drops nothing; later put
// misses simply replace the least recent entry. Write capacity only while no
// request is in flight. There is no clearing pass after reset: entries are
// valid in filling order, so the fill count alone marks which ones are live.
module lru_key_value_cache #(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned KEY_BITS    = 16,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write channel: capacity register.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]   i_cfg_data,
    // Request channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [KEY_BITS-1:0]         i_key,
    input  logic [VALUE_BITS-1:0]       i_value,
    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic [VALUE_BITS-1:0]       o_read_value,
    output logic                        o_evicted,
    output logic [KEY_BITS-1:0]         o_evicted_key
);
    import lkv_pkg::*;

    localparam int unsigned RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned FILL_W = $clog2(MAX_ENTRIES + 1);

    // Configuration register.
    logic [CAP_W-1:0]                       r_capacity;

    // Input register.
    logic                                   r_in_vld;
    logic                                   n_in_vld;
    logic                                   r_op;
    logic [KEY_BITS-1:0]                    r_key;
    logic [VALUE_BITS-1:0]                  r_value;

    // Result register.
    logic                                   r_out_vld;
    logic                                   n_out_vld;
    logic                                   r_hit;
    logic [VALUE_BITS-1:0]                  r_read_value;
    logic                                   r_evicted;
    logic [KEY_BITS-1:0]                    r_evicted_key;

    // Lookup and store connections.
    logic [MAX_ENTRIES-1:0][KEY_BITS-1:0]   keys;
    logic [MAX_ENTRIES-1:0][VALUE_BITS-1:0] values;
    logic [MAX_ENTRIES-1:0][RANK_W-1:0]     ranks;
    logic [FILL_W-1:0]                      fill;
    t_lkv_action                            action;
    logic [MAX_ENTRIES-1:0]                 sel;
    logic [RANK_W-1:0]                      rank_thr;
    logic                                   lk_hit;
    logic [VALUE_BITS-1:0]                  lk_read_value;
    logic                                   lk_evicted;
    logic [KEY_BITS-1:0]                    lk_evicted_key;

    logic                                   advance;
    logic                                   in_xfer;

    // The held request moves on when the result register is empty or its
    // content is being transferred out in this cycle.
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign n_in_vld  = in_xfer ? 1'b1 : (advance ? 1'b0 : r_in_vld);
    assign n_out_vld = advance ? 1'b1 : (i_out_stall ? r_out_vld : 1'b0);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op    <= i_operation;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (advance) begin
            r_hit         <= lk_hit;
            r_read_value  <= lk_read_value;
            r_evicted     <= lk_evicted;
            r_evicted_key <= lk_evicted_key;
        end
    end

    lkv_lookup #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS),
        .RANK_W      (RANK_W),
        .FILL_W      (FILL_W)
    ) u_lookup (
        .i_op          (r_op),
        .i_key         (r_key),
        .i_capacity    (r_capacity),
        .i_keys        (keys),
        .i_values      (values),
        .i_ranks       (ranks),
        .i_fill        (fill),
        .o_action      (action),
        .o_sel         (sel),
        .o_rank_thr    (rank_thr),
        .o_hit         (lk_hit),
        .o_read_value  (lk_read_value),
        .o_evicted     (lk_evicted),
        .o_evicted_key (lk_evicted_key)
    );

    lkv_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS),
        .RANK_W      (RANK_W),
        .FILL_W      (FILL_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (advance),
        .i_action   (action),
        .i_sel      (sel),
        .i_rank_thr (rank_thr),
        .i_key      (r_key),
        .i_value    (r_value),
        .o_keys     (keys),
        .o_values   (values),
        .o_ranks    (ranks),
        .o_fill     (fill)
    );

    assign o_out_valid   = r_out_vld;
    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

endmodule

### tb/sv/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key-value cache: random and directed get/put
// traffic against a behavioral cache model kept in step with every accepted request.
// Depends on lkv_pkg and lru_key_value_cache.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

    import lkv_pkg::*;

    localparam int unsigned ENTRIES     = 16;
    localparam int unsigned KEY_W       = 16;
    localparam int unsigned VAL_W       = 32;
    // The block holds a request in the input register and then in the result
    // register; SETTLE covers everything still in flight.
    localparam int unsigned SETTLE      = 4;
    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned IDLE_PCT    = 24;
    localparam int unsigned STUCK_LIMIT = 4000;
    localparam int unsigned PHASE_ITEMS = 112;

    typedef struct {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_request;

    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_response;

    logic             i_clk;
    logic             i_rst_n      = 1'b0;
    logic             i_cfg_valid  = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data   = '0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_stall;
    logic             i_operation  = 1'b0;
    logic [KEY_W-1:0] i_key        = '0;
    logic [VAL_W-1:0] i_value      = '0;
    logic             o_out_valid;
    logic             i_out_stall  = 1'b0;
    logic             o_hit;
    logic [VAL_W-1:0] o_read_value;
    logic             o_evicted;
    logic [KEY_W-1:0] o_evicted_key;

    lru_key_value_cache #(
        .MAX_ENTRIES (ENTRIES),
        .KEY_BITS    (KEY_W),
        .VALUE_BITS  (VAL_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    // Requests waiting to be offered, and responses the model says must come back.
    t_request  pending_requests[$];
    t_response expected_responses[$];

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned error_count    = 0;
    int unsigned stuck_cycles   = 0;
    int unsigned hold_left      = 0;
    int unsigned setting_count  = 0;

    // Phase controls; the sequencing process writes all but hold_done.
    logic quiet_phase = 1'b0;
    logic hold_armed  = 1'b0;
    logic hold_done   = 1'b0;

    // Cache model state. Ranks count age: 0 is the most recently used entry.
    logic [CAP_W-1:0] model_capacity;
    logic [KEY_W-1:0] model_keys   [ENTRIES];
    logic [VAL_W-1:0] model_values [ENTRIES];
    logic             model_valid  [ENTRIES];
    int unsigned      model_rank   [ENTRIES];
    int unsigned      model_fill;

    // What the run exercised, for the closing summary.
    int unsigned get_hits = 0, get_misses = 0, put_updates = 0, put_fills = 0;
    int unsigned put_evictions = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned usable_entries();
        if (model_capacity == 0)
            return 1;
        if (model_capacity > ENTRIES)
            return ENTRIES;
        return 32'(model_capacity);
    endfunction

    // Make entry idx the most recent; only entries younger than it get older.
    function automatic void promote_entry(int unsigned idx);
        int unsigned old_rank;
        old_rank = model_rank[idx];
        for (int i = 0; i < ENTRIES; i++) begin
            if (model_valid[i] && i != idx && model_rank[i] < old_rank)
                model_rank[i]++;
        end
        model_rank[idx] = 0;
    endfunction

    // Apply one request to the model and return the response the cache owes.
    function automatic t_response cache_access(t_request req);
        t_response   resp;
        bit          found;
        bit          any_valid;
        int unsigned slot;
        int unsigned oldest;
        resp      = '{1'b0, '0, 1'b0, '0};
        found     = 1'b0;
        any_valid = 1'b0;
        slot      = 0;
        oldest    = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!found && model_valid[i] && model_keys[i] == req.key) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            resp.hit = 1'b1;
            if (req.op == OP_GET) begin
                resp.read_value = model_values[slot];
                get_hits++;
            end else begin
                model_values[slot] = req.value;
                put_updates++;
            end
            promote_entry(slot);
        end else if (req.op == OP_GET) begin
            get_misses++;
        end else if (model_fill < usable_entries()) begin
            // Room left: the lowest free entry joins as the newest, all others age.
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!model_valid[i])
                    slot = i;
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (model_valid[i])
                    model_rank[i]++;
            end
            model_keys[slot]   = req.key;
            model_values[slot] = req.value;
            model_valid[slot]  = 1'b1;
            model_rank[slot]   = 0;
            model_fill++;
            put_fills++;
        end else begin
            // At or above capacity: the oldest entry is replaced, first one on a tie.
            for (int i = 0; i < ENTRIES; i++) begin
                if (model_valid[i] && (!any_valid || model_rank[i] > oldest)) begin
                    any_valid = 1'b1;
                    oldest    = model_rank[i];
                    slot      = i;
                end
            end
            if (any_valid) begin
                resp.evicted       = 1'b1;
                resp.evicted_key   = model_keys[slot];
                model_keys[slot]   = req.key;
                model_values[slot] = req.value;
                promote_entry(slot);
                put_evictions++;
            end
        end
        return resp;
    endfunction

    // Request driver. A new request is only presented when the previous one
    // has transferred or nothing was offered, so a stalled payload holds still.
    always @(posedge i_clk) begin : request_driver
        t_request next_req;
        if (i_in_valid && !o_in_stall) begin
            next_req.op    = t_op'(i_operation);
            next_req.key   = i_key;
            next_req.value = i_value;
            expected_responses = {expected_responses, cache_access(next_req)};
            accepted_count++;
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_requests.size() != 0
                    && (quiet_phase || $urandom_range(99) >= IDLE_PCT)) begin
                next_req    = pending_requests.pop_front();
                i_in_valid  <= 1'b1;
                i_operation <= next_req.op;
                i_key       <= next_req.key;
                i_value     <= next_req.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side stall. Once per run, when armed, it holds off for a long
    // stretch so the pipeline fills and the block has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_armed && !hold_done) begin
            hold_left   <= LONG_HOLD - 1;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet_phase && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Result checker: every transfer on the result channel is matched against
    // the oldest outstanding prediction.
    always @(posedge i_clk) begin : response_checker
        t_response want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_responses.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result hit=%0b read_value=%h evicted=%0b key=%h",
                         $time, o_hit, o_read_value, o_evicted, o_evicted_key);
            end else begin
                want = expected_responses.pop_front();
                if (o_hit !== want.hit) begin
                    error_count++;
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_hit);
                end
                if (o_read_value !== want.read_value) begin
                    error_count++;
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, o_read_value);
                end
                if (o_evicted !== want.evicted) begin
                    error_count++;
                    $display("%0t: evicted expected %0b actual %0b",
                             $time, want.evicted, o_evicted);
                end
                if (o_evicted_key !== want.evicted_key) begin
                    error_count++;
                    $display("%0t: evicted_key expected %h actual %h",
                             $time, want.evicted_key, o_evicted_key);
                end
            end
        end
    end

    // Watchdog: a run that stops moving in either direction is a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, STUCK_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic queue_request(t_op op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        t_request req;
        req.op    = op;
        req.key   = key;
        req.value = value;
        pending_requests = {pending_requests, req};
        queued_count++;
    endtask

    // The caller waits until every queued request has been answered.
    task automatic wait_drained();
        while (accepted_count != queued_count || expected_responses.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        model_capacity = cap;
        setting_count++;
        @(posedge i_clk);
    endtask

    // One random phase: most keys come from a small pool sized around the
    // capacity so gets hit and puts both update and evict; the rest are
    // arbitrary keys that almost always miss.
    task automatic random_phase(int unsigned count);
        logic [KEY_W-1:0] pool[$];
        int unsigned      pool_size;
        logic [KEY_W-1:0] key;
        pool_size = usable_entries() + 1 + $urandom_range(usable_entries());
        for (int i = 0; i < pool_size; i++)
            pool = {pool, KEY_W'($urandom_range(16'hFFFF))};
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 85)
                key = pool[$urandom_range(pool_size - 1)];
            else
                key = KEY_W'($urandom_range(16'hFFFF));
            queue_request(t_op'($urandom_range(1)), key, $urandom);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps[$];
        model_capacity = CAP_RESET;
        model_fill     = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            model_keys[i]   = '0;
            model_values[i] = '0;
            model_valid[i]  = 1'b0;
            model_rank[i]   = 0;
        end
        phase_caps = {5'd16, 5'd3, 5'd1, 5'd31, 5'd8, 5'd0,
                      5'd2, 5'd16, 5'd12, 5'd5, 5'd17, 5'd4};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed start at the reset capacity: extreme keys and values, a get
        // hit, a get miss and a put that updates an existing key.
        queue_request(OP_PUT, 16'h0000, 32'h0000_0000);
        queue_request(OP_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(OP_GET, 16'hFFFF, 32'h1234_5678);
        queue_request(OP_GET, 16'h0000, 32'hFFFF_FFFF);
        queue_request(OP_GET, 16'h1234, 32'h0000_0000);
        queue_request(OP_PUT, 16'hFFFF, 32'hA5A5_5A5A);
        queue_request(OP_GET, 16'hFFFF, 32'h0000_0000);
        wait_drained();

        // Capacity zero acts as one and sits below the two live entries, so
        // every put miss now evicts while the fill stays where it was.
        write_capacity(5'd0);
        queue_request(OP_PUT, 16'h0001, 32'h0000_0001);
        queue_request(OP_PUT, 16'h0002, 32'h8000_0000);
        queue_request(OP_GET, 16'h0002, 32'h0000_0000);
        queue_request(OP_GET, 16'h0001, 32'h0000_0000);
        queue_request(OP_PUT, 16'h0002, 32'h7FFF_FFFF);
        wait_drained();

        // The largest register value saturates to the number of entries.
        write_capacity(5'd31);
        queue_request(OP_PUT, 16'h8000, 32'h8000_0000);
        queue_request(OP_PUT, 16'h7FFF, 32'h7FFF_FFFF);
        queue_request(OP_GET, 16'h8000, 32'hFFFF_FFFF);
        queue_request(OP_GET, 16'h7FFF, 32'h0000_0000);
        queue_request(OP_PUT, 16'h1234, 32'h5555_5555);
        queue_request(OP_GET, 16'h1234, 32'hAAAA_AAAA);
        wait_drained();

        // Random phases. Cache contents carry over between settings, so a drop
        // in capacity leaves more live entries than the new limit allows.
        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            random_phase(PHASE_ITEMS);
            if (p == 7)
                quiet_phase <= 1'b1;
            if (p == 3) begin
                // Arm the long receiver hold once the phase is under way.
                while (accepted_count + PHASE_ITEMS - 30 > queued_count)
                    @(posedge i_clk);
                hold_armed <= 1'b1;
            end
            wait_drained();
            quiet_phase <= 1'b0;
            hold_armed  <= 1'b0;
        end

        repeat (SETTLE * 2) @(posedge i_clk);
        error_count += expected_responses.size();

        $display("Ran %0d requests over %0d capacity settings, including a long result stall.",
                 accepted_count, setting_count);
        $display("Gets: %0d hits, %0d misses. Puts: %0d updates, %0d fills, %0d evictions.",
                 get_hits, get_misses, put_updates, put_fills, put_evictions);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
